### sv/assert_macros.svh
// Assertion helpers shared by the clipper modules.
// Each module that uses them has clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define LSFC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When ante holds, cons must hold at the next edge.
`define LSFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/lsfc_pkg.sv
`timescale 1ns / 1ps
package lsfc_pkg;

  localparam int COORD_BITS = 16;
  localparam int CFG_BITS   = 16;
  // internal signed width: holds coordinate and frame differences without overflow
  localparam int WIDE_BITS  = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 3;
  localparam int MAG_BITS   = WIDE_BITS - 1;
  localparam int PROD_BITS  = 2 * MAG_BITS;
  localparam int QUO_BITS   = COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic [MAG_BITS-1:0]          mag_t;
  typedef logic [PROD_BITS-1:0]         prod_t;
  typedef logic [QUO_BITS-1:0]          quo_t;
  typedef logic [CFG_BITS-1:0]          cfg_word_t;

  localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  localparam cfg_word_t FRAME_WIDTH_RESET  = cfg_word_t'(640);
  localparam cfg_word_t FRAME_HEIGHT_RESET = cfg_word_t'(480);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } seg_t;

  typedef struct packed {
    logic                         visible;
    logic signed [COORD_BITS-1:0] left_x;
    logic signed [COORD_BITS-1:0] left_y;
    logic signed [COORD_BITS-1:0] right_x;
    logic signed [COORD_BITS-1:0] right_y;
  } clip_t;

  // segment state carried down the pipeline
  typedef struct packed {
    logic   done;     // single point or early reject: no more clipping
    logic   visible;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    wide_t  dx;
    wide_t  dy;
    wide_t  w1;       // frame_width - 1
    wide_t  h1;       // frame_height - 1
  } ctx_t;

  // one clip move: other + d * (t - c) / div
  typedef struct packed {
    logic   active;
    coord_t other;
    wide_t  d;
    wide_t  t;
    wide_t  c;
    wide_t  div;
  } mv_op_t;

  function automatic wide_t widen(coord_t v);
    return {{(WIDE_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic coord_t sat_coord(wide_t v);
    if (v > widen(CMAX)) return CMAX;
    if (v < widen(CMIN)) return CMIN;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic mag_t mag_of(wide_t v);
    wide_t n;
    n = v[WIDE_BITS-1] ? -v : v;
    return n[MAG_BITS-1:0];
  endfunction

  function automatic wide_t frame_limit(cfg_word_t f);
    wide_t z;
    z = {{(WIDE_BITS-CFG_BITS){1'b0}}, f};
    return z - wide_t'(1);
  endfunction

endpackage

### sv/lsfc_front.sv
`timescale 1ns / 1ps
module lsfc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              seg_valid,
  input  lsfc_pkg::seg_t    seg,
  input  lsfc_pkg::cfg_word_t frame_width,
  input  lsfc_pkg::cfg_word_t frame_height,
  output logic              ctx_valid,
  output lsfc_pkg::ctx_t    ctx
);
  import lsfc_pkg::*;

  logic   point;
  logic   swap;
  logic   reject;
  coord_t ax, ay, bx, by;
  wide_t  w1;
  ctx_t   ctx_next;

  always_comb begin
    point  = (seg.start_x == seg.end_x) && (seg.start_y == seg.end_y);
    swap   = seg.start_x > seg.end_x;
    ax     = swap ? seg.end_x   : seg.start_x;
    ay     = swap ? seg.end_y   : seg.start_y;
    bx     = swap ? seg.start_x : seg.end_x;
    by     = swap ? seg.start_y : seg.end_y;
    w1     = frame_limit(frame_width);
    reject = (bx < 0) || (widen(ax) > w1);

    ctx_next.done    = point || reject;
    ctx_next.visible = point || !reject;
    // a single point goes out as given
    ctx_next.ax      = point ? seg.start_x : ax;
    ctx_next.ay      = point ? seg.start_y : ay;
    ctx_next.bx      = point ? seg.end_x   : bx;
    ctx_next.by      = point ? seg.end_y   : by;
    ctx_next.dx      = widen(bx) - widen(ax);
    ctx_next.dy      = widen(by) - widen(ay);
    ctx_next.w1      = w1;
    ctx_next.h1      = frame_limit(frame_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_valid <= 1'b0;
    end else if (adv) begin
      ctx_valid <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx <= ctx_next;
    end
  end

endmodule

### sv/lsfc_move.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lsfc_move (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  lsfc_pkg::mv_op_t op,
  input  lsfc_pkg::ctx_t  in_ctx,
  output logic            out_valid,
  output lsfc_pkg::ctx_t  out_ctx,
  output lsfc_pkg::coord_t res,
  output logic            active
);
  import lsfc_pkg::*;

  localparam int HI_BITS = PROD_BITS - QUO_BITS;

  typedef struct packed {
    logic   active;
    logic   neg;
    logic   ovf;
    coord_t other;
    mag_t   den;
    mag_t   rem;
    quo_t   qsh;    // low dividend bits shift out, quotient bits shift in
  } dv_t;

  // operand register
  logic   v0;
  mv_op_t op0;
  ctx_t   ctx0;

  // signs and magnitudes
  logic   v1;
  ctx_t   ctx1;
  logic   act1, neg1;
  coord_t other1;
  mag_t   magd1, mags1, den1;

  // product
  logic   v2;
  ctx_t   ctx2;
  logic   act2, neg2;
  coord_t other2;
  mag_t   den2;
  prod_t  prod2;

  // restoring divider, one quotient bit per stage
  logic   vd [QUO_BITS+1];
  ctx_t   cd [QUO_BITS+1];
  dv_t    dv [QUO_BITS+1];

  wide_t  span;
  logic [HI_BITS-1:0] hi;
  logic   ovf_now;
  wide_t  base;
  wide_t  qext;
  coord_t res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      vd[0] <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      vd[0] <= v2;
    end
  end

  assign span = op0.t - op0.c;

  always_ff @(posedge clk) begin
    if (adv) begin
      op0    <= op;
      ctx0   <= in_ctx;

      ctx1   <= ctx0;
      act1   <= op0.active && (op0.div != '0);
      neg1   <= op0.d[WIDE_BITS-1] ^ span[WIDE_BITS-1] ^ op0.div[WIDE_BITS-1];
      other1 <= op0.other;
      magd1  <= mag_of(op0.d);
      mags1  <= mag_of(span);
      den1   <= mag_of(op0.div);

      ctx2   <= ctx1;
      act2   <= act1;
      neg2   <= neg1;
      other2 <= other1;
      den2   <= den1;
      prod2  <= magd1 * mags1;
    end
  end

  // quotient that does not fit in QUO_BITS saturates the result anyway
  assign hi      = prod2[PROD_BITS-1:QUO_BITS];
  assign ovf_now = hi >= {{(HI_BITS-MAG_BITS){1'b0}}, den2};

  always_ff @(posedge clk) begin
    if (adv) begin
      cd[0]       <= ctx2;
      dv[0].active <= act2;
      dv[0].neg   <= neg2;
      dv[0].ovf   <= ovf_now;
      dv[0].other <= other2;
      dv[0].den   <= den2;
      dv[0].rem   <= hi[MAG_BITS-1:0];
      dv[0].qsh   <= prod2[QUO_BITS-1:0];
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    logic [MAG_BITS:0] rem2;
    logic              ge;
    dv_t               nxt;

    always_comb begin
      rem2     = {dv[k].rem, dv[k].qsh[QUO_BITS-1]};
      ge       = rem2 >= {1'b0, dv[k].den};
      nxt      = dv[k];
      nxt.rem  = ge ? mag_t'(rem2 - {1'b0, dv[k].den}) : rem2[MAG_BITS-1:0];
      nxt.qsh  = {dv[k].qsh[QUO_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[k+1] <= 1'b0;
      end else if (adv) begin
        vd[k+1] <= vd[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k+1] <= nxt;
        cd[k+1] <= cd[k];
      end
    end
  end

  // add, round toward zero, saturate
  always_comb begin
    qext = {{(WIDE_BITS-QUO_BITS){1'b0}}, dv[QUO_BITS].qsh};
    base = dv[QUO_BITS].neg ? widen(dv[QUO_BITS].other) - qext
                            : widen(dv[QUO_BITS].other) + qext;
    if (dv[QUO_BITS].rem != '0) begin
      if (base > 0 && dv[QUO_BITS].neg) begin
        base = base - wide_t'(1);
      end else if (base < 0 && !dv[QUO_BITS].neg) begin
        base = base + wide_t'(1);
      end
    end
    if (!dv[QUO_BITS].active) begin
      res_next = dv[QUO_BITS].other;
    end else if (dv[QUO_BITS].ovf) begin
      res_next = dv[QUO_BITS].neg ? CMIN : CMAX;
    end else begin
      res_next = sat_coord(base);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vd[QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ctx <= cd[QUO_BITS];
      res     <= res_next;
      active  <= dv[QUO_BITS].active;
    end
  end

  `LSFC_ASSERT(a_rem_below_den, !(vd[QUO_BITS] && dv[QUO_BITS].active && !dv[QUO_BITS].ovf) || (dv[QUO_BITS].rem < dv[QUO_BITS].den), "divider remainder not below divisor")
  `LSFC_ASSERT_NEXT(a_ovf_saturates, adv && vd[QUO_BITS] && dv[QUO_BITS].active && dv[QUO_BITS].ovf, (res == CMAX) || (res == CMIN), "quotient overflow did not saturate")

endmodule

### sv/line_segment_frame_clipper.sv
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// seg       in         seg_valid / seg_stall  seg (start_x, start_y, end_x, end_y)
// clip      out        clip_valid / clip_stall clip (visible, left/right x, y)
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One segment enters per cycle while the result is not stalled. The pipeline is
// the front stage, four chained clip moves (each a multiplier and a
// one-bit-per-stage divider) and the output register.
// rst is synchronous and clears all valid bits; frame size resets to 640 x 480.
// A stalled result freezes the whole pipeline; seg_stall follows from it.
// cfg_ready is always high.
`include "assert_macros.svh"
module line_segment_frame_clipper (
  input  logic                clk,
  input  logic                rst,
  input  logic                seg_valid,
  output logic                seg_stall,
  input  lsfc_pkg::seg_t      seg,
  output logic                clip_valid,
  input  logic                clip_stall,
  output lsfc_pkg::clip_t     clip,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  lsfc_pkg::cfg_reg_t  cfg_index,
  input  lsfc_pkg::cfg_word_t cfg_data
);
  import lsfc_pkg::*;

  logic      adv;
  cfg_word_t frame_width;
  cfg_word_t frame_height;

  logic   f_valid, a_valid, b_valid, c_valid, d_valid;
  ctx_t   f_ctx, a_ctx, b_ctx, c_ctx, d_ctx;
  ctx_t   a_wb, b_wb, c_wb, d_wb;
  coord_t a_res, b_res, c_res, d_res;
  logic   a_act, b_act, c_act, d_act;
  mv_op_t op_a, op_b, op_c, op_d;
  clip_t  clip_next;

  assign adv       = !(clip_valid && clip_stall);
  assign seg_stall = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  lsfc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .seg_valid    (seg_valid),
    .seg          (seg),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .ctx_valid    (f_valid),
    .ctx          (f_ctx)
  );

  // right endpoint, x clip to the right edge
  always_comb begin
    op_a.active = !f_ctx.done && (widen(f_ctx.bx) > f_ctx.w1);
    op_a.other  = f_ctx.by;
    op_a.d      = f_ctx.dy;
    op_a.t      = f_ctx.w1;
    op_a.c      = widen(f_ctx.bx);
    op_a.div    = f_ctx.dx;
  end

  lsfc_move u_move_a (
    .clk (clk), .rst (rst), .adv (adv),
    .in_valid (f_valid), .op (op_a), .in_ctx (f_ctx),
    .out_valid (a_valid), .out_ctx (a_ctx), .res (a_res), .active (a_act)
  );

  always_comb begin
    a_wb = a_ctx;
    if (a_act) begin
      a_wb.by = a_res;
      a_wb.bx = sat_coord(a_ctx.w1);
    end
  end

  // right endpoint, y clip
  always_comb begin
    op_b.active = !a_wb.done && (a_wb.dy != '0) &&
                  ((widen(a_wb.by) > a_wb.h1) || (a_wb.by < 0));
    op_b.other  = a_wb.bx;
    op_b.d      = a_wb.dx;
    op_b.t      = (widen(a_wb.by) > a_wb.h1) ? a_wb.h1 : '0;
    op_b.c      = widen(a_wb.by);
    op_b.div    = a_wb.dy;
  end

  lsfc_move u_move_b (
    .clk (clk), .rst (rst), .adv (adv),
    .in_valid (a_valid), .op (op_b), .in_ctx (a_wb),
    .out_valid (b_valid), .out_ctx (b_ctx), .res (b_res), .active (b_act)
  );

  // the ctx still holds the pre-move y, so the target is picked again here
  always_comb begin
    b_wb = b_ctx;
    if (b_act) begin
      b_wb.bx = b_res;
      b_wb.by = (widen(b_ctx.by) > b_ctx.h1) ? sat_coord(b_ctx.h1) : '0;
    end
  end

  // left endpoint, x clip to the left edge
  always_comb begin
    op_c.active = !b_wb.done && (b_wb.ax < 0);
    op_c.other  = b_wb.ay;
    op_c.d      = b_wb.dy;
    op_c.t      = '0;
    op_c.c      = widen(b_wb.ax);
    op_c.div    = b_wb.dx;
  end

  lsfc_move u_move_c (
    .clk (clk), .rst (rst), .adv (adv),
    .in_valid (b_valid), .op (op_c), .in_ctx (b_wb),
    .out_valid (c_valid), .out_ctx (c_ctx), .res (c_res), .active (c_act)
  );

  always_comb begin
    c_wb = c_ctx;
    if (c_act) begin
      c_wb.ay = c_res;
      c_wb.ax = '0;
    end
  end

  // left endpoint, y clip
  always_comb begin
    op_d.active = !c_wb.done && (c_wb.dy != '0) &&
                  ((widen(c_wb.ay) > c_wb.h1) || (c_wb.ay < 0));
    op_d.other  = c_wb.ax;
    op_d.d      = c_wb.dx;
    op_d.t      = (widen(c_wb.ay) > c_wb.h1) ? c_wb.h1 : '0;
    op_d.c      = widen(c_wb.ay);
    op_d.div    = c_wb.dy;
  end

  lsfc_move u_move_d (
    .clk (clk), .rst (rst), .adv (adv),
    .in_valid (c_valid), .op (op_d), .in_ctx (c_wb),
    .out_valid (d_valid), .out_ctx (d_ctx), .res (d_res), .active (d_act)
  );

  always_comb begin
    d_wb = d_ctx;
    if (d_act) begin
      d_wb.ax = d_res;
      d_wb.ay = (widen(d_ctx.ay) > d_ctx.h1) ? sat_coord(d_ctx.h1) : '0;
    end
  end

  // final x test after clipping; done segments keep their early decision
  always_comb begin
    clip_next.visible = d_wb.done ? d_wb.visible
                                  : !((d_wb.bx < 0) || (widen(d_wb.ax) > d_wb.w1));
    clip_next.left_x  = d_wb.ax;
    clip_next.left_y  = d_wb.ay;
    clip_next.right_x = d_wb.bx;
    clip_next.right_y = d_wb.by;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_valid <= 1'b0;
    end else if (adv) begin
      clip_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clip <= clip_next;
    end
  end

  `LSFC_ASSERT(a_right_clip_ctx, !(a_valid && a_act) || (widen(a_ctx.bx) > a_ctx.w1), "right x clip done on a segment inside the frame")
  `LSFC_ASSERT_NEXT(a_done_keeps_flag, adv && d_valid && d_wb.done, clip.visible == $past(d_wb.visible), "early decision lost at output")

endmodule

### bench/clip_checker.sv
`timescale 1ns / 1ps
module clip_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                seg_valid,
  input  logic                seg_stall,
  input  lsfc_pkg::seg_t      seg,
  input  logic                clip_valid,
  input  logic                clip_stall,
  input  lsfc_pkg::clip_t     clip,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  lsfc_pkg::cfg_reg_t  cfg_index,
  input  lsfc_pkg::cfg_word_t cfg_data,
  output int                  fail_count,
  output int                  pending
);
  import lsfc_pkg::*;

  localparam longint CLO = -(64'sd1 <<< (COORD_BITS - 1));
  localparam longint CHI = (64'sd1 <<< (COORD_BITS - 1)) - 1;

  cfg_word_t width_q, height_q;
  clip_t     expected_clips[$];

  function automatic longint clamp(longint v);
    if (v > CHI) return CHI;
    if (v < CLO) return CLO;
    return v;
  endfunction

  // other + d*(t-c)/div, exact, truncated toward zero, saturated
  function automatic longint clip_move(longint other, longint d, longint t, longint c,
                                       longint div);
    longint span, base;
    bit neg;
    longint unsigned prod, den, q, r;
    if (div == 0) return other;
    span = t - c;
    neg = (d < 0) ^ (span < 0) ^ (div < 0);
    prod = longint'(d < 0 ? -d : d) * longint'(span < 0 ? -span : span);
    den = div < 0 ? -div : div;
    q = prod / den;
    r = prod % den;
    if (q >= (64'd1 << 40)) return neg ? CLO : CHI;
    base = neg ? other - longint'(q) : other + longint'(q);
    if (r != 0) begin
      if (base > 0 && neg) base -= 1;
      else if (base < 0 && !neg) base += 1;
    end
    return clamp(base);
  endfunction

  function automatic clip_t clip_segment(seg_t s, cfg_word_t fw, cfg_word_t fh);
    longint ax, ay, bx, by, w, h, dx, dy, tmp;
    bit vis;
    clip_t o;
    ax = s.start_x; ay = s.start_y; bx = s.end_x; by = s.end_y;
    w = fw; h = fh;
    vis = 1;
    if (!(ax == bx && ay == by)) begin
      if (ax > bx) begin
        tmp = ax; ax = bx; bx = tmp;
        tmp = ay; ay = by; by = tmp;
      end
      if (bx < 0 || ax >= w) begin
        vis = 0;
      end else begin
        dx = bx - ax;
        dy = by - ay;
        if (bx >= w) begin
          by = clip_move(by, dy, w - 1, bx, dx);
          bx = clamp(w - 1);
        end
        if (dy != 0) begin
          if (by >= h) begin
            bx = clip_move(bx, dx, h - 1, by, dy);
            by = clamp(h - 1);
          end else if (by < 0) begin
            bx = clip_move(bx, dx, 0, by, dy);
            by = 0;
          end
        end
        if (ax < 0) begin
          ay = clip_move(ay, dy, 0, ax, dx);
          ax = 0;
        end
        if (dy != 0) begin
          if (ay >= h) begin
            ax = clip_move(ax, dx, h - 1, ay, dy);
            ay = clamp(h - 1);
          end else if (ay < 0) begin
            ax = clip_move(ax, dx, 0, ay, dy);
            ay = 0;
          end
        end
        if (bx < 0 || ax >= w) vis = 0;
      end
    end
    o.visible = vis;
    o.left_x = ax[COORD_BITS-1:0];
    o.left_y = ay[COORD_BITS-1:0];
    o.right_x = bx[COORD_BITS-1:0];
    o.right_y = by[COORD_BITS-1:0];
    return o;
  endfunction

  assign pending = expected_clips.size();

  always @(posedge clk) begin
    clip_t exp_c;
    if (rst) begin
      width_q <= FRAME_WIDTH_RESET;
      height_q <= FRAME_HEIGHT_RESET;
      fail_count <= 0;
      expected_clips.delete();
    end else begin
      if (seg_valid && !seg_stall)
        expected_clips.push_back(clip_segment(seg, width_q, height_q));
      if (clip_valid && !clip_stall) begin
        if (expected_clips.size() == 0) begin
          if (fail_count < 10) $display("unexpected item: %p", clip);
          fail_count <= fail_count + 1;
        end else begin
          exp_c = expected_clips.pop_front();
          if (clip !== exp_c) begin
            if (fail_count < 10) $display("mismatch: expected %p, got %p", exp_c, clip);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_q <= cfg_data;
          REG_FRAME_HEIGHT: height_q <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

### bench/tb_line_segment_frame_clipper.sv
`timescale 1ns / 1ps
module tb_line_segment_frame_clipper;
  import lsfc_pkg::*;

  localparam int LATENCY = 4 * (COORD_BITS + 5) + 2;
  localparam int IDLE_LIMIT = 20 * LATENCY + 2000;

  logic      clk, rst;
  logic      seg_valid, seg_stall, clip_valid, clip_stall;
  seg_t      seg;
  clip_t     clip;
  logic      cfg_valid, cfg_ready;
  cfg_reg_t  cfg_index;
  cfg_word_t cfg_data;
  int        fail_count, pending;
  bit        calm, hold_rx;
  int        idle_cycles;

  line_segment_frame_clipper i_dut (.*);
  clip_checker i_chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // receiver: random stall bursts, none near the end; long hold-off on request
  initial begin
    int n;
    clip_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_rx) clip_stall <= 1;
      else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        clip_stall <= 1;
        repeat (n) @(negedge clk);
        clip_stall <= 0;
      end else clip_stall <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (seg_valid && !seg_stall) || (clip_valid && !clip_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // valid stays up on return; the next call or drain() decides what follows
  task automatic send_seg(logic [15:0] sx, logic [15:0] sy, logic [15:0] ex, logic [15:0] ey);
    if (!calm && $urandom_range(0, 4) == 0) begin
      seg_valid <= 0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    seg_valid <= 1;
    seg <= '{sx, sy, ex, ey};
    @(posedge clk);
    while (seg_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    seg_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, cfg_word_t v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coord(int fw, int fh, bit yaxis);
    int lim;
    lim = yaxis ? fh : fw;
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return $urandom_range(0, 3) == 0 ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, lim + 40)) - 20);
    endcase
  endfunction

  task automatic random_phase(int count, int fw, int fh);
    logic [15:0] x0, y0;
    repeat (count) begin
      x0 = rand_coord(fw, fh, 0);
      y0 = rand_coord(fw, fh, 1);
      if ($urandom_range(0, 15) == 0) send_seg(x0, y0, x0, y0);
      else send_seg(x0, y0, rand_coord(fw, fh, 0), rand_coord(fw, fh, 1));
    end
  endtask

  initial begin
    rst = 1;
    seg_valid = 0;
    seg = '0;
    cfg_valid = 0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    calm = 0;
    hold_rx = 0;
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed, reset frame 640x480
    send_seg(16'd5, 16'd5, 16'd5, 16'd5);              // single point
    send_seg(16'h8000, 16'h8000, 16'h8000, 16'h8000);  // single point outside
    send_seg(16'd700, 16'd10, 16'd10, 16'd20);         // swap
    send_seg(16'hfff0, 16'd0, 16'hffff, 16'd9);        // left reject
    send_seg(16'd640, 16'd0, 16'd900, 16'd9);          // right reject
    send_seg(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);  // extremes
    send_seg(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_seg(16'hffce, 16'd100, 16'd800, 16'd100);     // horizontal, dy zero
    send_seg(16'd100, 16'hff00, 16'd100, 16'd900);     // vertical
    send_seg(16'd10, 16'd600, 16'd20, 16'd700);        // below frame, final reject
    send_seg(16'd0, 16'd0, 16'd639, 16'd479);
    send_seg(16'hffff, 16'hffff, 16'd640, 16'd480);
    send_seg(16'h7fff, 16'd0, 16'h7ffe, 16'hffff);
    send_seg(16'd3, 16'h8000, 16'd600, 16'h7fff);      // y moves land inside frame
    drain();

    write_reg(REG_FRAME_WIDTH, 16'd1);
    write_reg(REG_FRAME_HEIGHT, 16'd1);
    send_seg(16'd0, 16'd0, 16'd1, 16'd1);
    send_seg(16'hffff, 16'd0, 16'd5, 16'd3);
    random_phase(40, 1, 1);
    drain();

    // zero frame: targets become -1
    write_reg(REG_FRAME_WIDTH, 16'd0);
    write_reg(REG_FRAME_HEIGHT, 16'd0);
    send_seg(16'hfffe, 16'd3, 16'd4, 16'hfffc);
    random_phase(20, 0, 0);
    drain();

    write_reg(REG_FRAME_WIDTH, 16'hffff);
    write_reg(REG_FRAME_HEIGHT, 16'hffff);
    random_phase(80, 65535, 65535);

    // long receiver hold-off while items keep coming
    fork
      begin
        hold_rx = 1;
        repeat (LATENCY * 3) @(negedge clk);
        hold_rx = 0;
      end
      random_phase(150, 65535, 65535);
    join
    drain();

    write_reg(REG_FRAME_WIDTH, 16'd640);
    write_reg(REG_FRAME_HEIGHT, 16'd480);
    random_phase(100, 640, 480);
    drain();

    write_reg(REG_FRAME_WIDTH, 16'd37);
    write_reg(REG_FRAME_HEIGHT, 16'd1000);
    random_phase(50, 37, 1000);
    calm = 1;
    random_phase(50, 37, 1000);
    drain();

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
